// ----- rtl/rmst_pkg.sv -----
// Shared constants, types and helpers for the range minimum segment tree.
package rmst_pkg;

  localparam int LEAVES   = 1024;
  localparam int LEAF_W   = $clog2(LEAVES);
  localparam int NODES    = 2 * LEAVES;
  localparam int NODE_W   = $clog2(NODES);
  localparam int BND_W    = NODE_W + 1;
  localparam int DATA_W   = 32;
  localparam int TDATA_W  = ((2 * LEAF_W + DATA_W + 7) / 8) * 8;
  localparam int LVL_W    = 4;
  localparam int UPD_STEPS = LEAF_W;
  localparam int QRY_STEPS = LEAF_W + 2;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [NODE_W-1:0]        node_t;
  typedef logic [BND_W-1:0]         bnd_t;

  localparam data_t MIN_IDENTITY = 32'sd2000000000;

  typedef struct packed {
    logic clr_step;
    logic load_upd;
    logic upd_step;
    logic load_qry;
    logic qry_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_busy;
  } dp_sts_t;

  function automatic data_t min_of(input data_t x, input data_t y);
    return (y < x) ? y : x;
  endfunction

endpackage

// ----- rtl/rmst_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ----- rtl/rmst_ctrl.sv -----
// Controller state machine: clearing pass, update climb, query climb, result hand-off.
module rmst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  input  rmst_pkg::dp_sts_t sts,
  output rmst_pkg::dp_cmd_t cmd
);
  import rmst_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_QRY  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state, state_next;
  logic [LVL_W-1:0] lvl, lvl_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    lvl_next   = lvl;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          lvl_next = '0;
          if (s_tuser == OP_UPDATE) begin
            cmd.load_upd = 1'b1;
            state_next   = ST_UPD;
          end else begin
            cmd.load_qry = 1'b1;
            state_next   = ST_QRY;
          end
        end
      end
      ST_UPD: begin
        cmd.upd_step = 1'b1;
        lvl_next     = lvl + 1'b1;
        if (lvl == LVL_W'(UPD_STEPS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_QRY: begin
        cmd.qry_step = 1'b1;
        lvl_next     = lvl + 1'b1;
        if (lvl == LVL_W'(QRY_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      lvl   <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
    end
  end

endmodule

// ----- rtl/rmst_dp.sv -----
// Datapath: node memory, update and query climb registers, output register.
module rmst_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  rmst_pkg::dp_cmd_t              cmd,
  output rmst_pkg::dp_sts_t              sts,
  input  logic [rmst_pkg::TDATA_W-1:0]   in_data,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [rmst_pkg::DATA_W-1:0]    m_tdata
);
  import rmst_pkg::*;

  logic [LEAF_W-1:0] left_index, right_index;
  data_t             value;

  assign left_index  = in_data[LEAF_W-1:0];
  assign right_index = in_data[2*LEAF_W-1:LEAF_W];
  assign value       = data_t'(in_data[2*LEAF_W+DATA_W-1:2*LEAF_W]);

  node_t clr_addr;
  node_t k, k_next;
  data_t cur, cur_next;
  bnd_t  a, a_next, b, b_next, b_minus;
  logic  use_a, use_b, use_a_next, use_b_next, live;
  data_t fl, fl_next, fr, fr_next;

  logic  we;
  node_t waddr, ra_addr, rb_addr;
  data_t wdata, rd_a, rd_b;
  node_t leaf_node, upd_parent;
  data_t upd_min;

  assign leaf_node  = NODE_W'(LEAVES) + NODE_W'(left_index);
  assign upd_parent = k >> 1;
  assign upd_min    = min_of(cur, rd_a);
  assign b_minus    = b - 1'b1;
  assign live       = (a < b);

  always_comb begin
    we       = 1'b0;
    waddr    = clr_addr;
    wdata    = MIN_IDENTITY;
    ra_addr  = a[NODE_W-1:0];
    rb_addr  = b_minus[NODE_W-1:0];
    k_next   = k;
    cur_next = cur;
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.load_upd) begin
      we       = 1'b1;
      waddr    = leaf_node;
      wdata    = value;
      ra_addr  = leaf_node ^ NODE_W'(1);
      k_next   = leaf_node;
      cur_next = value;
    end else if (cmd.upd_step) begin
      we       = 1'b1;
      waddr    = upd_parent;
      wdata    = upd_min;
      ra_addr  = upd_parent ^ NODE_W'(1);
      k_next   = upd_parent;
      cur_next = upd_min;
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    a_next     = a;
    b_next     = b;
    use_a_next = use_a;
    use_b_next = use_b;
    fl_next    = fl;
    fr_next    = fr;
    priority if (cmd.load_qry) begin
      a_next     = BND_W'(LEAVES) + BND_W'(left_index);
      b_next     = BND_W'(LEAVES) + BND_W'(right_index) + BND_W'(1);
      use_a_next = 1'b0;
      use_b_next = 1'b0;
      fl_next    = MIN_IDENTITY;
      fr_next    = MIN_IDENTITY;
    end else if (cmd.qry_step) begin
      if (use_a) begin
        fl_next = min_of(fl, rd_a);
      end
      if (use_b) begin
        fr_next = min_of(rd_b, fr);
      end
      use_a_next = live & a[0];
      use_b_next = live & b[0];
      a_next     = (a + BND_W'(a[0])) >> 1;
      b_next     = b >> 1;
    end else begin
      a_next = a;
    end
  end

  rmst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODES)
  ) u_nodes (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (rd_a),
    .rb_addr (rb_addr),
    .rb_data (rd_b)
  );

  always_ff @(posedge clk) begin
    k     <= k_next;
    cur   <= cur_next;
    a     <= a_next;
    b     <= b_next;
    use_a <= use_a_next;
    use_b <= use_b_next;
    fl    <= fl_next;
    fr    <= fr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= min_of(fl, fr);
    end
  end

  assign sts.clr_done = (clr_addr == NODE_W'(NODES - 1));
  assign sts.out_busy = m_tvalid & ~m_tready;

endmodule

// ----- rtl/range_min_segment_tree_unit.sv -----
// Top level of the range minimum segment tree: controller, datapath, checks.
// Update: the transfer cycle writes the leaf, then one ancestor per cycle
//   over 10 levels, paced by the sibling read of the node memory.
// Query: 12 climb steps on the two read ports plus the final compare produce
//   the result, which then waits in the output register.
// Reset: synchronous; a clearing pass then writes 2000000000 to every node,
//   with s_tready low until it is done.
module range_min_segment_tree_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // left_index[9:0], right_index[19:10], value[51:20], zero pad[55:52]
  input  logic [rmst_pkg::TDATA_W-1:0]   s_tdata,
  // operation[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // minimum[31:0]
  output logic [rmst_pkg::DATA_W-1:0]    m_tdata
);
  import rmst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmst_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.load_upd, cmd.upd_step}))
    else $error("node memory has more than one write source");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a pending transfer");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.upd_step || cmd.qry_step || cmd.clr_step))
    else $error("input ready while a climb or clear is running");

  a_update_silent: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_UPDATE) |=> !cmd.out_load)
    else $error("update produced a result");

endmodule
